[hw/rtl/sfc_pkg.sv]
// Shared types, constants and the multiply schedule of the segment set fit cost block.
package sfc_pkg;

    localparam int COORD_W = 32;
    localparam int SEG_W   = 6 * COORD_W;
    localparam int DIST_W  = 64;
    localparam int ACC_W   = 68;
    localparam int NACC_W  = 134;
    localparam int OPND_W  = 34;
    localparam int NUM_SRC = 15;
    localparam int NUM_ACC = 8;
    localparam int STEP_W  = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd29;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_SCORE = 2'd2;

    // Multiplier operand sources: segment vector, point vectors, cross product halves.
    typedef enum logic [3:0] {
        SRC_AX  = 4'd0,  SRC_AY  = 4'd1,  SRC_AZ  = 4'd2,
        SRC_BX  = 4'd3,  SRC_BY  = 4'd4,  SRC_BZ  = 4'd5,
        SRC_CX  = 4'd6,  SRC_CY  = 4'd7,  SRC_CZ  = 4'd8,
        SRC_M1H = 4'd9,  SRC_M1L = 4'd10,
        SRC_M2H = 4'd11, SRC_M2L = 4'd12,
        SRC_M3H = 4'd13, SRC_M3L = 4'd14
    } src_t;

    // Accumulator targets.
    typedef enum logic [3:0] {
        DST_D  = 4'd0, DST_T1 = 4'd1, DST_T2 = 4'd2, DST_E1 = 4'd3,
        DST_E2 = 4'd4, DST_M1 = 4'd5, DST_M2 = 4'd6, DST_M3 = 4'd7,
        DST_N  = 4'd8
    } dst_t;

    typedef enum logic [1:0] {
        SHF_0  = 2'd0,
        SHF_34 = 2'd1,
        SHF_66 = 2'd2
    } shf_t;

    typedef struct packed {
        src_t x;
        src_t y;
        dst_t dst;
        shf_t shf;
        logic neg;
    } mop_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] value;
        logic              sat;
    } dist_res_t;

    // One multiply-accumulate per step for a single point/segment pair.
    function automatic mop_t mop_at(logic [STEP_W-1:0] step);
        mop_t m;
        m = '{SRC_AX, SRC_AX, DST_D, SHF_0, 1'b0};
        case (step)
            5'd0:  m = '{SRC_AX, SRC_AX, DST_D,  SHF_0, 1'b0};
            5'd1:  m = '{SRC_AY, SRC_AY, DST_D,  SHF_0, 1'b0};
            5'd2:  m = '{SRC_AZ, SRC_AZ, DST_D,  SHF_0, 1'b0};
            5'd3:  m = '{SRC_CX, SRC_AX, DST_T1, SHF_0, 1'b0};
            5'd4:  m = '{SRC_CY, SRC_AY, DST_T1, SHF_0, 1'b0};
            5'd5:  m = '{SRC_CZ, SRC_AZ, DST_T1, SHF_0, 1'b0};
            5'd6:  m = '{SRC_BX, SRC_AX, DST_T2, SHF_0, 1'b0};
            5'd7:  m = '{SRC_BY, SRC_AY, DST_T2, SHF_0, 1'b0};
            5'd8:  m = '{SRC_BZ, SRC_AZ, DST_T2, SHF_0, 1'b0};
            5'd9:  m = '{SRC_CX, SRC_CX, DST_E1, SHF_0, 1'b0};
            5'd10: m = '{SRC_CY, SRC_CY, DST_E1, SHF_0, 1'b0};
            5'd11: m = '{SRC_CZ, SRC_CZ, DST_E1, SHF_0, 1'b0};
            5'd12: m = '{SRC_BX, SRC_BX, DST_E2, SHF_0, 1'b0};
            5'd13: m = '{SRC_BY, SRC_BY, DST_E2, SHF_0, 1'b0};
            5'd14: m = '{SRC_BZ, SRC_BZ, DST_E2, SHF_0, 1'b0};
            5'd15: m = '{SRC_AY, SRC_BZ, DST_M1, SHF_0, 1'b0};
            5'd16: m = '{SRC_AZ, SRC_BY, DST_M1, SHF_0, 1'b1};
            5'd17: m = '{SRC_AZ, SRC_BX, DST_M2, SHF_0, 1'b0};
            5'd18: m = '{SRC_AX, SRC_BZ, DST_M2, SHF_0, 1'b1};
            5'd19: m = '{SRC_AX, SRC_BY, DST_M3, SHF_0, 1'b0};
            5'd20: m = '{SRC_AY, SRC_BX, DST_M3, SHF_0, 1'b1};
            5'd21: m = '{SRC_M1H, SRC_M1H, DST_N, SHF_66, 1'b0};
            5'd22: m = '{SRC_M1H, SRC_M1L, DST_N, SHF_34, 1'b0};
            5'd23: m = '{SRC_M1L, SRC_M1L, DST_N, SHF_0,  1'b0};
            5'd24: m = '{SRC_M2H, SRC_M2H, DST_N, SHF_66, 1'b0};
            5'd25: m = '{SRC_M2H, SRC_M2L, DST_N, SHF_34, 1'b0};
            5'd26: m = '{SRC_M2L, SRC_M2L, DST_N, SHF_0,  1'b0};
            5'd27: m = '{SRC_M3H, SRC_M3H, DST_N, SHF_66, 1'b0};
            5'd28: m = '{SRC_M3H, SRC_M3L, DST_N, SHF_34, 1'b0};
            5'd29: m = '{SRC_M3L, SRC_M3L, DST_N, SHF_0,  1'b0};
            default: m = '{SRC_AX, SRC_AX, DST_D, SHF_0, 1'b0};
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/sfc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module sfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/sfc_dist.sv]
// Squared point-to-segment distance unit: one shared multiplier and a restoring divider.
module sfc_dist (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [sfc_pkg::SEG_W-1:0]             seg,
    input  logic signed [sfc_pkg::COORD_W-1:0]    px,
    input  logic signed [sfc_pkg::COORD_W-1:0]    py,
    input  logic signed [sfc_pkg::COORD_W-1:0]    pz,
    output sfc_pkg::dist_res_t                    res
);
    import sfc_pkg::*;

    typedef enum logic [4:0] {
        D_IDLE  = 5'b00001,
        D_MUL   = 5'b00010,
        D_FLUSH = 5'b00100,
        D_DEC   = 5'b01000,
        D_DIV   = 5'b10000
    } dstate_t;

    dstate_t state_reg, state_next;

    logic [STEP_W-1:0] step_reg;
    logic [5:0]        dcnt_reg;
    logic              done_reg;
    logic [DIST_W-1:0] val_reg;
    logic              sat_reg;

    logic signed [COORD_W:0] va_reg [3];
    logic signed [COORD_W:0] vb_reg [3];
    logic signed [COORD_W:0] vc_reg [3];

    logic signed [ACC_W-1:0]  acc_reg [NUM_ACC];
    logic signed [NACC_W-1:0] n_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic                     pv_reg;
    dst_t                     pdst_reg;
    shf_t                     pshf_reg;
    logic                     pneg_reg;

    logic [ACC_W-1:0]  rem_reg;
    logic [DIST_W-1:0] nlo_reg;

    mop_t                    op;
    logic signed [OPND_W-1:0] opnd [NUM_SRC];
    logic signed [OPND_W-1:0] opx;
    logic signed [OPND_W-1:0] opy;
    logic signed [NACC_W-1:0] addn;
    logic signed [NACC_W-1:0] pext;

    logic signed [COORD_W:0] sx, sy, sz, ex, ey, ez, qx, qy, qz;
    logic [ACC_W-1:0] d_val;
    logic [ACC_W-1:0] e_min;
    logic             endpt;
    logic             ovf;
    logic [ACC_W-1:0] r2;
    logic             qbit;

    assign sx = {seg[191], seg[191:160]};
    assign sy = {seg[159], seg[159:128]};
    assign sz = {seg[127], seg[127:96]};
    assign ex = {seg[95],  seg[95:64]};
    assign ey = {seg[63],  seg[63:32]};
    assign ez = {seg[31],  seg[31:0]};
    assign qx = {px[COORD_W-1], px};
    assign qy = {py[COORD_W-1], py};
    assign qz = {pz[COORD_W-1], pz};

    always_comb
    begin
        op       = mop_at(step_reg);
        opnd[0]  = {va_reg[0][COORD_W], va_reg[0]};
        opnd[1]  = {va_reg[1][COORD_W], va_reg[1]};
        opnd[2]  = {va_reg[2][COORD_W], va_reg[2]};
        opnd[3]  = {vb_reg[0][COORD_W], vb_reg[0]};
        opnd[4]  = {vb_reg[1][COORD_W], vb_reg[1]};
        opnd[5]  = {vb_reg[2][COORD_W], vb_reg[2]};
        opnd[6]  = {vc_reg[0][COORD_W], vc_reg[0]};
        opnd[7]  = {vc_reg[1][COORD_W], vc_reg[1]};
        opnd[8]  = {vc_reg[2][COORD_W], vc_reg[2]};
        // A cross component is split into a signed high half and an unsigned low half.
        opnd[9]  = acc_reg[3'(DST_M1)][66:33];
        opnd[10] = {1'b0, acc_reg[3'(DST_M1)][32:0]};
        opnd[11] = acc_reg[3'(DST_M2)][66:33];
        opnd[12] = {1'b0, acc_reg[3'(DST_M2)][32:0]};
        opnd[13] = acc_reg[3'(DST_M3)][66:33];
        opnd[14] = {1'b0, acc_reg[3'(DST_M3)][32:0]};
        opx      = opnd[op.x];
        opy      = opnd[op.y];
    end

    always_comb
    begin
        pext = {{(NACC_W-ACC_W){prod_reg[ACC_W-1]}}, prod_reg};
        case (pshf_reg)
            SHF_0:   addn = pext;
            SHF_34:  addn = pext <<< 34;
            SHF_66:  addn = pext <<< 66;
            default: addn = pext;
        endcase
    end

    always_comb
    begin
        d_val = acc_reg[3'(DST_D)];
        endpt = (acc_reg[3'(DST_D)] == '0) || (acc_reg[3'(DST_T1)] > 0) ||
                (acc_reg[3'(DST_T2)] < 0);
        e_min = (acc_reg[3'(DST_E1)] <= acc_reg[3'(DST_E2)]) ? acc_reg[3'(DST_E1)]
                                                             : acc_reg[3'(DST_E2)];
        ovf   = n_reg[131:64] >= d_val;
        r2    = {rem_reg[ACC_W-2:0], nlo_reg[DIST_W-1]};
        qbit  = r2 >= d_val;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:  if (start) state_next = D_MUL;
            D_MUL:   if (step_reg == LAST_STEP) state_next = D_FLUSH;
            D_FLUSH: state_next = D_DEC;
            D_DEC:   state_next = (endpt || ovf) ? D_IDLE : D_DIV;
            D_DIV:   if (dcnt_reg == 6'd63) state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
            dcnt_reg  <= '0;
            done_reg  <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= (state_reg == D_MUL);
            if (state_reg == D_IDLE)
            begin
                step_reg <= '0;
            end
            else if (state_reg == D_MUL)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == D_DEC)
            begin
                dcnt_reg <= '0;
                done_reg <= endpt || ovf;
            end
            else if (state_reg == D_DIV)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
                done_reg <= (dcnt_reg == 6'd63);
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opx * opy;
        pdst_reg <= op.dst;
        pshf_reg <= op.shf;
        pneg_reg <= op.neg;
        if (state_reg == D_IDLE && start)
        begin
            va_reg[0] <= sx - ex;
            va_reg[1] <= sy - ey;
            va_reg[2] <= sz - ez;
            vb_reg[0] <= qx - ex;
            vb_reg[1] <= qy - ey;
            vb_reg[2] <= qz - ez;
            vc_reg[0] <= qx - sx;
            vc_reg[1] <= qy - sy;
            vc_reg[2] <= qz - sz;
            for (int k = 0; k < NUM_ACC; k++)
            begin
                acc_reg[k] <= '0;
            end
            n_reg <= '0;
        end
        else if (pv_reg)
        begin
            for (int k = 0; k < NUM_ACC; k++)
            begin
                if (pdst_reg == dst_t'(k))
                begin
                    acc_reg[k] <= pneg_reg ? acc_reg[k] - prod_reg : acc_reg[k] + prod_reg;
                end
            end
            if (pdst_reg == DST_N)
            begin
                n_reg <= pneg_reg ? n_reg - addn : n_reg + addn;
            end
        end
        if (state_reg == D_DEC)
        begin
            rem_reg <= n_reg[131:64];
            nlo_reg <= n_reg[63:0];
            if (endpt)
            begin
                sat_reg <= (e_min[ACC_W-1:DIST_W] != '0);
                val_reg <= (e_min[ACC_W-1:DIST_W] != '0) ? '1 : e_min[DIST_W-1:0];
            end
            else
            begin
                sat_reg <= 1'b1;
                val_reg <= '1;
            end
        end
        else if (state_reg == D_DIV)
        begin
            rem_reg <= qbit ? r2 - d_val : r2;
            nlo_reg <= {nlo_reg[DIST_W-2:0], qbit};
            sat_reg <= 1'b0;
            val_reg <= {nlo_reg[DIST_W-2:0], qbit};
        end
    end

    assign res.done  = done_reg;
    assign res.value = val_reg;
    assign res.sat   = sat_reg;

endmodule

[hw/rtl/segment_set_fit_cost_top.sv]
// Top level of the segment set fit cost block: segment store, scoring control, running cost.
//
// Input beats carry kind, group and two points ax..az, bx..by..bz.
// A clear beat empties both segment groups and zeroes the running cost.
// A load beat appends segment (a, b) to its group; a full group ignores it.
// A score beat compares point a with every stored segment of its group and emits one
// output beat: the least squared distance, the new running cost, and two flags.
// Segments live in one RAM; each is read, then run through a distance unit built on a
// single shared 34x34 multiplier (30 multiplies) and a one-bit-per-cycle divider.
// A segment whose nearest point is an endpoint finishes after the multiplies and the
// endpoint check; when the perpendicular foot lies on the segment, the divider also
// runs, unless the quotient would overflow and the distance saturates.
// An empty group skips the segment RAM and goes straight to T_FIN.
// The block works on one beat at a time: in_ready is high only between items.
// A finished result sits in an output register; if the receiver stalls, the block
// still accepts the next beat, and a second result waits until the register drains.
// Reset clears the group counts, the cost and all control state; segment RAM contents
// are not cleared, since only entries below a group's count are ever read.
module segment_set_fit_cost_top #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           kind,
    input  logic                                 group,
    input  logic signed [sfc_pkg::COORD_W-1:0]   ax,
    input  logic signed [sfc_pkg::COORD_W-1:0]   ay,
    input  logic signed [sfc_pkg::COORD_W-1:0]   az,
    input  logic signed [sfc_pkg::COORD_W-1:0]   bx,
    input  logic signed [sfc_pkg::COORD_W-1:0]   by,
    input  logic signed [sfc_pkg::COORD_W-1:0]   bz,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sfc_pkg::DIST_W-1:0]           point_sq_dist,
    output logic [sfc_pkg::DIST_W-1:0]           total_cost,
    output logic                                 no_segments,
    output logic                                 saturated
);
    import sfc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int DEPTH  = 2 * MAX_SEGMENTS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,
        T_RD    = 5'b00010,
        T_START = 5'b00100,
        T_WAIT  = 5'b01000,
        T_FIN   = 5'b10000
    } tstate_t;

    tstate_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg [2];
    logic [DIST_W-1:0]  cost_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               grp_reg;
    logic               first_reg;
    logic               empty_reg;
    logic [DIST_W-1:0]  best_reg;
    logic               bsat_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;

    logic               out_valid_reg;
    logic [DIST_W-1:0]  dist_out_reg;
    logic [DIST_W-1:0]  cost_out_reg;
    logic               nos_out_reg;
    logic               sat_out_reg;

    logic               in_acc;
    logic [CNT_W-1:0]   in_cnt;
    logic [CNT_W-1:0]   grp_cnt;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [SEG_W-1:0]   rd_data;
    logic               take;
    logic               last_seg;
    logic               out_free;
    logic [DIST_W:0]    cost_sum;
    dist_res_t          res;

    assign in_ready = (state_reg == T_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign in_cnt   = group ? cnt_reg[1] : cnt_reg[0];
    assign grp_cnt  = grp_reg ? cnt_reg[1] : cnt_reg[0];
    assign out_free = !out_valid_reg || out_ready;

    // Group 1 occupies the upper half of the segment RAM.
    assign wr_en   = in_acc && (kind == KIND_LOAD) && (in_cnt < CNT_W'(MAX_SEGMENTS));
    assign wr_addr = ADDR_W'(in_cnt) + (group ? ADDR_W'(MAX_SEGMENTS) : ADDR_W'(0));
    assign rd_addr = ADDR_W'(idx_reg) + (grp_reg ? ADDR_W'(MAX_SEGMENTS) : ADDR_W'(0));

    sfc_ram #(
        .WIDTH (SEG_W),
        .DEPTH (DEPTH)
    ) u_seg_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({ax, ay, az, bx, by, bz}),
        .rd_en   (state_reg == T_RD),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfc_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == T_START),
        .seg   (rd_data),
        .px    (px_reg),
        .py    (py_reg),
        .pz    (pz_reg),
        .res   (res)
    );

    // An unsaturated distance beats a saturated one; otherwise the smaller value wins,
    // and on a tie the earlier segment is kept.
    assign take = first_reg || (!res.sat && bsat_reg) ||
                  ((res.sat == bsat_reg) && (res.value < best_reg));
    assign last_seg = (CNT_W'(idx_reg + 1'b1) == grp_cnt);
    assign cost_sum = {1'b0, cost_reg} + {1'b0, best_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (in_acc && kind == KIND_SCORE)
                begin
                    state_next = (in_cnt == '0) ? T_FIN : T_RD;
                end
            end
            T_RD:    state_next = T_START;
            T_START: state_next = T_WAIT;
            T_WAIT:
            begin
                if (res.done)
                begin
                    state_next = last_seg ? T_FIN : T_RD;
                end
            end
            T_FIN:   if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            cost_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            first_reg     <= 1'b0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == T_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_acc)
            begin
                case (kind)
                    KIND_CLEAR:
                    begin
                        cnt_reg[0] <= '0;
                        cnt_reg[1] <= '0;
                        cost_reg   <= '0;
                    end
                    KIND_LOAD:
                    begin
                        if (wr_en)
                        begin
                            cnt_reg[group] <= in_cnt + 1'b1;
                        end
                    end
                    KIND_SCORE:
                    begin
                        idx_reg   <= '0;
                        first_reg <= 1'b1;
                        empty_reg <= (in_cnt == '0);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == T_WAIT && res.done)
            begin
                idx_reg   <= idx_reg + 1'b1;
                first_reg <= 1'b0;
            end
            if (state_reg == T_FIN && out_free)
            begin
                if (!empty_reg)
                begin
                    cost_reg <= cost_sum[DIST_W] ? '1 : cost_sum[DIST_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            grp_reg <= group;
            px_reg  <= ax;
            py_reg  <= ay;
            pz_reg  <= az;
        end
        if (state_reg == T_WAIT && res.done && take)
        begin
            best_reg <= res.value;
            bsat_reg <= res.sat;
        end
        if (state_reg == T_FIN && out_free)
        begin
            if (empty_reg)
            begin
                dist_out_reg <= '0;
                cost_out_reg <= cost_reg;
                nos_out_reg  <= 1'b1;
                sat_out_reg  <= 1'b0;
            end
            else
            begin
                dist_out_reg <= best_reg;
                cost_out_reg <= cost_sum[DIST_W] ? '1 : cost_sum[DIST_W-1:0];
                nos_out_reg  <= 1'b0;
                sat_out_reg  <= bsat_reg || cost_sum[DIST_W];
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign point_sq_dist = dist_out_reg;
    assign total_cost    = cost_out_reg;
    assign no_segments   = nos_out_reg;
    assign saturated     = sat_out_reg;

    // Group counts never pass the capacity of a group.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CNT_W'(MAX_SEGMENTS) && cnt_reg[1] <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count exceeds group capacity");

    // A score beat always occupies the block for at least the following cycle.
    a_score_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == KIND_SCORE) |=> !in_ready)
        else $error("input accepted right after a score beat");

    // An empty-group result carries a zero distance and no saturation.
    a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_segments) |-> (point_sq_dist == '0 && !saturated))
        else $error("empty-group result carries a distance");

    // The distance unit only finishes while the controller waits for it.
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> state_reg == T_WAIT)
        else $error("distance result arrived outside the wait state");

endmodule
